### hdl/s2d_pkg.sv
// ----------------------------------------------------------------------------
// s2d_pkg: shared types and constants for the signed binary to decimal ASCII
// converter. Holds the operand width, the derived digit counts, character
// codes, the sequencer states and the control bundle of the conversion unit.
// ----------------------------------------------------------------------------
package s2d_pkg;

	localparam int VALUE_BITS = 32;
	// Decimal digits needed for 2**VALUE_BITS - 1: floor(bits * log10(2)) + 1.
	localparam int DIGITS     = (VALUE_BITS * 30103) / 100000 + 1;
	localparam int DIGIT_BITS = DIGITS * 4;
	localparam int CNT_W      = $clog2(DIGITS + 1);
	localparam int DIG_IDX_W  = $clog2(DIGITS);
	localparam int BIT_CNT_W  = $clog2(VALUE_BITS);

	localparam logic [7:0] ASCII_ZERO  = 8'h30;
	localparam logic [7:0] ASCII_MINUS = 8'h2D;

	typedef logic [DIGITS-1:0][3:0] s2d_digits_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CONV,
		ST_COUNT,
		ST_SIGN,
		ST_DIGITS
	} s2d_state_t;

	typedef struct packed {
		logic load;
		logic shift;
	} s2d_ctrl_t;

endpackage

### hdl/s2d_if.sv
// ----------------------------------------------------------------------------
// s2d channel interfaces
// Valid/ready channels for the input number and for the output characters.
// ----------------------------------------------------------------------------
interface s2d_num_if import s2d_pkg::*; ();
	logic                         valid;
	logic                         ready;
	logic signed [VALUE_BITS-1:0] value;

	modport source (output valid, output value, input ready);
	modport sink   (input valid, input value, output ready);
endinterface

interface s2d_char_if import s2d_pkg::*; ();
	logic       valid;
	logic       ready;
	logic [7:0] character;
	logic       last;

	modport source (output valid, output character, output last, input ready);
	modport sink   (input valid, input character, input last, output ready);
endinterface

### hdl/s2d_dabble.sv
// ----------------------------------------------------------------------------
// s2d_dabble: shift-and-add-3 conversion unit
// Holds the binary magnitude and the BCD digits. Each shift step adds 3 to
// every digit of 5 or more and then shifts one magnitude bit into the digits.
// ----------------------------------------------------------------------------
module s2d_dabble import s2d_pkg::*; (
	input  logic                  clk,
	input  s2d_ctrl_t             ctrl,
	input  logic [VALUE_BITS-1:0] magnitude,
	output s2d_digits_t           digits
);

	logic [VALUE_BITS-1:0] bin_q;
	logic [DIGIT_BITS-1:0] bcd_q;
	logic [DIGIT_BITS-1:0] adj;

	always_comb begin
		for (int d = 0; d < DIGITS; d++) begin
			if (bcd_q[d*4 +: 4] >= 4'd5) begin
				adj[d*4 +: 4] = bcd_q[d*4 +: 4] + 4'd3;
			end else begin
				adj[d*4 +: 4] = bcd_q[d*4 +: 4];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			bin_q <= magnitude;
			bcd_q <= '0;
		end else if (ctrl.shift) begin
			bin_q <= {bin_q[VALUE_BITS-2:0], 1'b0};
			bcd_q <= {adj[DIGIT_BITS-2:0], bin_q[VALUE_BITS-1]};
		end
	end

	assign digits = bcd_q;

endmodule

### hdl/s2d_seq.sv
// ----------------------------------------------------------------------------
// s2d_seq: conversion sequencer and character output stage
// Takes a number, runs the conversion unit for one step per magnitude bit,
// finds the leading digit and then sends the sign and digits as beats.
// ----------------------------------------------------------------------------
module s2d_seq import s2d_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	s2d_num_if.sink               num,
	s2d_char_if.source            text,
	input  s2d_digits_t           digits,
	output s2d_ctrl_t             ctrl,
	output logic [VALUE_BITS-1:0] magnitude
);

	s2d_state_t            state_q, state_d;
	logic [BIT_CNT_W-1:0]  bit_cnt_q;
	logic [CNT_W-1:0]      idx_q;
	logic [CNT_W-1:0]      idx_m1;
	logic [CNT_W-1:0]      ndig;
	logic                  neg_q;
	logic                  valid_q;
	logic [7:0]            char_q;
	logic                  last_q;
	logic                  slot_free;
	logic                  out_load;
	logic [7:0]            char_d;
	logic                  last_d;
	logic [VALUE_BITS-1:0] raw;

	assign raw       = num.value;
	assign magnitude = raw[VALUE_BITS-1] ? (~raw + VALUE_BITS'(1)) : raw;
	assign slot_free = !valid_q || text.ready;
	assign idx_m1    = idx_q - CNT_W'(1);

	// Number of significant digits; zero still prints one digit.
	always_comb begin
		ndig = CNT_W'(1);
		for (int d = 1; d < DIGITS; d++) begin
			if (digits[d] != 4'd0) begin
				ndig = CNT_W'(d + 1);
			end
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (num.valid) state_d = ST_CONV;
			end
			ST_CONV: begin
				if (bit_cnt_q == '0) state_d = ST_COUNT;
			end
			ST_COUNT: begin
				state_d = neg_q ? ST_SIGN : ST_DIGITS;
			end
			ST_SIGN: begin
				if (slot_free) state_d = ST_DIGITS;
			end
			ST_DIGITS: begin
				if (slot_free && idx_q == CNT_W'(1)) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		num.ready  = 1'b0;
		ctrl.load  = 1'b0;
		ctrl.shift = 1'b0;
		out_load   = 1'b0;
		char_d     = ASCII_MINUS;
		last_d     = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				num.ready = 1'b1;
				ctrl.load = num.valid;
			end
			ST_CONV: begin
				ctrl.shift = 1'b1;
			end
			ST_COUNT: begin
			end
			ST_SIGN: begin
				out_load = slot_free;
			end
			ST_DIGITS: begin
				out_load = slot_free;
				char_d   = ASCII_ZERO + {4'd0, digits[idx_m1[DIG_IDX_W-1:0]]};
				last_d   = (idx_q == CNT_W'(1));
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			bit_cnt_q <= '0;
			idx_q     <= '0;
			neg_q     <= 1'b0;
			valid_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ctrl.load) begin
				bit_cnt_q <= BIT_CNT_W'(VALUE_BITS - 1);
				neg_q     <= raw[VALUE_BITS-1];
			end else if (ctrl.shift) begin
				bit_cnt_q <= bit_cnt_q - BIT_CNT_W'(1);
			end
			if (state_q == ST_COUNT) begin
				idx_q <= ndig;
			end else if (out_load && state_q == ST_DIGITS) begin
				idx_q <= idx_m1;
			end
			if (out_load) begin
				valid_q <= 1'b1;
			end else if (text.ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			char_q <= char_d;
			last_q <= last_d;
		end
	end

	assign text.valid     = valid_q;
	assign text.character = char_q;
	assign text.last      = last_q;

endmodule

### hdl/signed_binary_to_decimal_ascii.sv
// ----------------------------------------------------------------------------
// signed_binary_to_decimal_ascii: signed integer to decimal ASCII text
//
// The num channel takes one signed 32-bit two's complement value per beat.
// The text channel returns its decimal text, most significant character
// first: a '-' for negative values, then the digits with no leading zeros
// (zero gives a single '0'). The final character of a number has last set.
// The most negative value prints correctly.
//
// After a beat is taken, the shift-and-add-3 unit runs one step per input
// bit, the ST_COUNT state finds the leading digit, and the characters
// then follow one per cycle through the output register while the
// receiver is ready. num.ready is high only while no conversion is in
// progress.
//
// Reset clears the sequencer and the output valid; no clearing pass is
// needed. When the receiver stalls, the current character holds in the
// output register and the sequencer waits for it to be taken.
// ----------------------------------------------------------------------------
module signed_binary_to_decimal_ascii import s2d_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	s2d_num_if.sink    num,
	s2d_char_if.source text
);

	s2d_ctrl_t             ctrl;
	s2d_digits_t           digits;
	logic [VALUE_BITS-1:0] magnitude;

	s2d_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.num       (num),
		.text      (text),
		.digits    (digits),
		.ctrl      (ctrl),
		.magnitude (magnitude)
	);

	s2d_dabble u_dabble (
		.clk       (clk),
		.ctrl      (ctrl),
		.magnitude (magnitude),
		.digits    (digits)
	);

endmodule

### hdl/s2d_checker.sv
// ----------------------------------------------------------------------------
// s2d_checker: port-level checks for the decimal ASCII converter
// Watches the number and character channels of the top level.
// ----------------------------------------------------------------------------
module s2d_checker import s2d_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       num_valid,
	input logic       num_ready,
	input logic       text_valid,
	input logic       text_ready,
	input logic [7:0] text_character,
	input logic       text_last
);

	// A stalled character beat stays offered.
	assert property (@(posedge clk) disable iff (!arst_n)
		text_valid && !text_ready |=> text_valid)
		else $error("character beat dropped while stalled");

	// Only a sign or a decimal digit is ever sent.
	assert property (@(posedge clk) disable iff (!arst_n)
		text_valid |-> (text_character == ASCII_MINUS ||
			(text_character >= ASCII_ZERO && text_character <= ASCII_ZERO + 8'd9)))
		else $error("character is not a sign or a digit");

	// Within one number the characters follow without a gap.
	assert property (@(posedge clk) disable iff (!arst_n)
		text_valid && text_ready && !text_last |=> text_valid)
		else $error("gap inside a number's text");

	// No new number is taken while a number's text is still being sent.
	assert property (@(posedge clk) disable iff (!arst_n)
		text_valid && !text_last |-> !num_ready)
		else $error("input ready during a number's text");

	// Taking a number starts a conversion that blocks the input.
	assert property (@(posedge clk) disable iff (!arst_n)
		num_valid && num_ready |=> !num_ready)
		else $error("input ready right after a number was taken");

endmodule

bind signed_binary_to_decimal_ascii s2d_checker u_s2d_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.num_valid      (num.valid),
	.num_ready      (num.ready),
	.text_valid     (text.valid),
	.text_ready     (text.ready),
	.text_character (text.character),
	.text_last      (text.last)
);

### bench/testbench.sv
// ----------------------------------------------------------------------------
// Testbench for signed_binary_to_decimal_ascii
// Sends signed 32-bit numbers on the num channel: first the edge values, then
// random numbers of every length and sign. It predicts each number's decimal
// text and checks every character beat and its last flag in order. Both
// channels idle in random bursts. One long receiver stall backs the block up,
// and one sender pause lets the block drain completely.
// ----------------------------------------------------------------------------
module testbench;
	import s2d_pkg::*;

	localparam int RANDOM_ITEMS       = 260;
	localparam int TAIL_ITEMS         = 30;
	localparam int LONG_STALL_AFTER   = 60;
	localparam int LONG_STALL_CYCLES  = 300;
	localparam int DRAIN_PAUSE_ITEM   = 150;
	localparam int SETTLE_CYCLES      = 60;
	localparam int WATCHDOG_LIMIT     = 3000;
	localparam int REPORT_LIMIT       = 10;

	typedef struct packed {
		logic [7:0] character;
		logic       last;
	} text_beat_t;

	logic clk;
	logic arst_n;

	s2d_num_if  num_ch ();
	s2d_char_if text_ch ();

	signed_binary_to_decimal_ascii uut (
		.clk    (clk),
		.arst_n (arst_n),
		.num    (num_ch),
		.text   (text_ch)
	);

	logic [VALUE_BITS-1:0] pending_numbers[$];
	bit                    pending_drain[$];
	text_beat_t            expected_text[$];

	int  mismatches;
	int  numbers_taken;
	int  idle_cycles;
	bit  num_taken;
	int  send_gap;
	bit  send_idling;
	int  recv_gap;
	int  stall_left;
	bit  stall_done;
	bit  recv_idling;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Decimal text of one number, pushed onto the expected character queue.
	function automatic void predict_text(input logic [VALUE_BITS-1:0] raw);
		logic [VALUE_BITS-1:0] magnitude;
		logic [3:0]            digit_buf[DIGITS];
		int                    count;
		bit                    negative;
		text_beat_t            beat;
		negative  = raw[VALUE_BITS-1];
		magnitude = negative ? (~raw + 1'b1) : raw;
		count     = 0;
		do begin
			digit_buf[count] = 4'(magnitude % 10);
			count++;
			magnitude = magnitude / 10;
		end while (magnitude != 0);
		if (negative) begin
			beat.character = ASCII_MINUS;
			beat.last      = 1'b0;
			expected_text.push_back(beat);
		end
		for (int i = count - 1; i >= 0; i--) begin
			beat.character = ASCII_ZERO + 8'(digit_buf[i]);
			beat.last      = (i == 0);
			expected_text.push_back(beat);
		end
	endfunction

	function automatic void queue_number(input longint number, input bit drain_first);
		pending_numbers.push_back(VALUE_BITS'(number));
		pending_drain.push_back(drain_first);
	endfunction

	// Random number of a random digit length and sign, so that short and long
	// texts both turn up often.
	function automatic longint random_number();
		longint lo;
		longint hi;
		longint magnitude;
		int     digits;
		bit     negative;
		negative = $urandom_range(0, 1);
		digits   = $urandom_range(1, 10);
		lo = 1;
		for (int i = 1; i < digits; i++)
			lo = lo * 10;
		hi = (digits == 1) ? 9 : lo * 10 - 1;
		if (digits == 1)
			lo = 0;
		if (hi > 64'sd2147483647)
			hi = negative ? 64'sd2147483648 : 64'sd2147483647;
		magnitude = lo + longint'($urandom_range(0, 32'(hi - lo)));
		return negative ? -magnitude : magnitude;
	endfunction

	// Item acceptance, result checking and prediction, all on the rising edge.
	always @(posedge clk) begin
		if (arst_n) begin
			if (num_ch.valid && num_ch.ready) begin
				predict_text(num_ch.value);
				numbers_taken++;
				num_taken = 1'b1;
			end
			if (text_ch.valid && text_ch.ready) begin
				if (expected_text.size() == 0) begin
					if (mismatches < REPORT_LIMIT)
						$display("unexpected text beat: character %h last %b",
							text_ch.character, text_ch.last);
					mismatches++;
				end else begin
					if (text_ch.character !== expected_text[0].character ||
						text_ch.last !== expected_text[0].last) begin
						if (mismatches < REPORT_LIMIT)
							$display("text mismatch: expected %h/%b, got %h/%b",
								expected_text[0].character, expected_text[0].last,
								text_ch.character, text_ch.last);
						mismatches++;
					end
					void'(expected_text.pop_front());
				end
			end
			if ((num_ch.valid && num_ch.ready) || (text_ch.valid && text_ch.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("[signed_binary_to_decimal_ascii] ERROR");
				$finish;
			end
		end
	end

	// Number driver: one beat held until taken, random gaps between beats.
	always @(negedge clk) begin
		logic next_valid;
		if (!arst_n) begin
			num_ch.valid <= 1'b0;
		end else begin
			next_valid = num_ch.valid;
			if (num_taken) begin
				num_taken = 1'b0;
				next_valid = 1'b0;
				void'(pending_numbers.pop_front());
				void'(pending_drain.pop_front());
				if ($urandom_range(0, 15) == 0)
					send_idling = !send_idling;
				if (send_idling && pending_numbers.size() > TAIL_ITEMS &&
					$urandom_range(0, 2) == 0)
					send_gap = $urandom_range(1, 9);
			end
			if (!next_valid) begin
				if (send_gap > 0) begin
					send_gap--;
				end else if (pending_numbers.size() > 0 &&
					!(pending_drain[0] && expected_text.size() != 0)) begin
					next_valid = 1'b1;
					num_ch.value <= pending_numbers[0];
				end
			end
			num_ch.valid <= next_valid;
		end
	end

	// Text receiver: random ready bursts and one long hold-off.
	always @(negedge clk) begin
		logic next_ready;
		if (!arst_n) begin
			text_ch.ready <= 1'b0;
		end else begin
			next_ready = 1'b1;
			if ($urandom_range(0, 99) == 0)
				recv_idling = !recv_idling;
			if (!stall_done && numbers_taken >= LONG_STALL_AFTER) begin
				stall_done = 1'b1;
				stall_left = LONG_STALL_CYCLES;
			end
			if (stall_left > 0) begin
				stall_left--;
				next_ready = 1'b0;
			end else if (recv_gap > 0) begin
				recv_gap--;
				next_ready = 1'b0;
			end else if (recv_idling && pending_numbers.size() > TAIL_ITEMS &&
				$urandom_range(0, 5) == 0) begin
				recv_gap = $urandom_range(1, 9) - 1;
				next_ready = 1'b0;
			end
			text_ch.ready <= next_ready;
		end
	end

	initial begin
		clk           = 1'b0;
		arst_n        = 1'b0;
		num_ch.valid  = 1'b0;
		num_ch.value  = '0;
		text_ch.ready = 1'b0;
		mismatches    = 0;
		numbers_taken = 0;
		idle_cycles   = 0;
		num_taken     = 1'b0;
		send_gap      = 0;
		send_idling   = 1'b1;
		recv_gap      = 0;
		stall_left    = 0;
		stall_done    = 1'b0;
		recv_idling   = 1'b1;

		// Edge values: zero, single digits, digit-count boundaries, the
		// extremes of the range and the most negative value.
		queue_number(0, 0);
		queue_number(1, 0);
		queue_number(-1, 0);
		queue_number(9, 0);
		queue_number(-9, 0);
		queue_number(10, 0);
		queue_number(-10, 0);
		queue_number(99, 0);
		queue_number(100, 0);
		queue_number(-100, 0);
		queue_number(123456789, 0);
		queue_number(-123456789, 0);
		queue_number(999999999, 0);
		queue_number(1000000000, 0);
		queue_number(-1000000000, 0);
		queue_number(1000000007, 0);
		queue_number(64'sd2147483647, 0);
		queue_number(-64'sd2147483647, 0);
		queue_number(-64'sd2147483648, 0);
		queue_number(0, 0);
		queue_number(-64'sd2147483648, 0);

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			case ($urandom_range(0, 3))
				0: queue_number(longint'($signed($urandom())), i == DRAIN_PAUSE_ITEM);
				1: queue_number($urandom_range(0, 20) - 10, i == DRAIN_PAUSE_ITEM);
				default: queue_number(random_number(), i == DRAIN_PAUSE_ITEM);
			endcase
		end

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (pending_numbers.size() != 0 || expected_text.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (mismatches == 0 && expected_text.size() == 0)
			$display("[signed_binary_to_decimal_ascii] OK");
		else
			$display("[signed_binary_to_decimal_ascii] ERROR");
		$finish;
	end

endmodule

### files.f
hdl/s2d_pkg.sv
hdl/s2d_if.sv
hdl/s2d_dabble.sv
hdl/s2d_seq.sv
hdl/signed_binary_to_decimal_ascii.sv
hdl/s2d_checker.sv
bench/testbench.sv
